/* hw/rtl/pbs_pkg.sv */
// shared types and constants for the power button sequencer
`default_nettype none

package pbs_pkg;

    // register file layout
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STARTUP_MS      = 3'd0,
        CFG_SHUTDOWN_MS     = 3'd1,
        CFG_ABSENCE_LIMIT   = 3'd2,
        CFG_DEBOUNCE_MS     = 3'd3,
        CFG_ABSENCE_STEP_MS = 3'd4
    } t_cfg_idx;

    // register reset values
    localparam logic [15:0] STARTUP_MS_RST      = 16'd40000;
    localparam logic [15:0] SHUTDOWN_MS_RST     = 16'd40000;
    localparam logic [3:0]  ABSENCE_LIMIT_RST   = 4'd10;
    localparam logic [9:0]  DEBOUNCE_MS_RST     = 10'd100;
    localparam logic [9:0]  ABSENCE_STEP_MS_RST = 10'd1000;

    // sequencer modes
    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_ON       = 2'd1,
        MODE_SHUTDOWN = 2'd2
    } t_mode;

    localparam int unsigned ELAPSED_W = 17;
    localparam int unsigned ABSENCE_W = 5;
    localparam int unsigned WAIT_W    = 10;

    // current register values
    typedef struct packed {
        logic [15:0] startup_ms;
        logic [15:0] shutdown_ms;
        logic [3:0]  absence_limit;
        logic [9:0]  debounce_ms;
        logic [9:0]  absence_step_ms;
    } t_cfg;

    // one result word
    typedef struct packed {
        logic       relay_closed;
        logic       shutdown_signal;
        logic [1:0] mode_code;
        logic       waiting;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/pbs_in_if.sv */
// input tick channel: valid/ready with button and detect levels
`default_nettype none

interface pbs_in_if;
    logic valid;
    logic ready;
    logic button_level;
    logic detect_level;

    modport source (output valid, output button_level, output detect_level, input ready);
    modport sink   (input valid, input button_level, input detect_level, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pbs_out_if.sv */
// result channel: valid/ready with relay, shutdown, mode and wait flags
`default_nettype none

interface pbs_out_if;
    logic       valid;
    logic       ready;
    logic       relay_closed;
    logic       shutdown_signal;
    logic [1:0] mode_code;
    logic       waiting;

    modport source (
        output valid, output relay_closed, output shutdown_signal,
        output mode_code, output waiting, input ready
    );
    modport sink (
        input valid, input relay_closed, input shutdown_signal,
        input mode_code, input waiting, output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/pbs_cfg_regs.sv */
// configuration register file, write only
`default_nettype none

module pbs_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_we,
    input  wire logic [pbs_pkg::CFG_IDX_W-1:0]     i_idx,
    input  wire logic [pbs_pkg::CFG_DATA_W-1:0]    i_data,
    output pbs_pkg::t_cfg                          o_cfg
);

    pbs_pkg::t_cfg r_cfg;

    // register writes, data truncated to each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.startup_ms      <= pbs_pkg::STARTUP_MS_RST;
            r_cfg.shutdown_ms     <= pbs_pkg::SHUTDOWN_MS_RST;
            r_cfg.absence_limit   <= pbs_pkg::ABSENCE_LIMIT_RST;
            r_cfg.debounce_ms     <= pbs_pkg::DEBOUNCE_MS_RST;
            r_cfg.absence_step_ms <= pbs_pkg::ABSENCE_STEP_MS_RST;
        end else if (i_we) begin
            case (i_idx)
                pbs_pkg::CFG_STARTUP_MS:      r_cfg.startup_ms      <= i_data[15:0];
                pbs_pkg::CFG_SHUTDOWN_MS:     r_cfg.shutdown_ms     <= i_data[15:0];
                pbs_pkg::CFG_ABSENCE_LIMIT:   r_cfg.absence_limit   <= i_data[3:0];
                pbs_pkg::CFG_DEBOUNCE_MS:     r_cfg.debounce_ms     <= i_data[9:0];
                pbs_pkg::CFG_ABSENCE_STEP_MS: r_cfg.absence_step_ms <= i_data[9:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hw/rtl/pbs_core.sv */
// sequencer state and per-tick next-state logic
`default_nettype none

module pbs_core (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire logic      i_button,
    input  wire logic      i_detect,
    input  wire pbs_pkg::t_cfg i_cfg,
    output pbs_pkg::t_result o_res
);

    pbs_pkg::t_mode                  r_mode,    n_mode;
    logic [pbs_pkg::ELAPSED_W-1:0]   r_elapsed, n_elapsed;
    logic [pbs_pkg::ABSENCE_W-1:0]   r_absence, n_absence;
    logic                            r_prev,    n_prev;
    logic [pbs_pkg::WAIT_W-1:0]      r_wait,    n_wait;
    logic                            waited;
    logic [pbs_pkg::ELAPSED_W-1:0]   elapsed_inc;
    logic                            past_startup;
    logic                            past_shutdown;
    logic                            may_count;
    logic                            do_detect;
    logic                            go_off;

    // saturating tick count and timeout compares
    always_comb begin
        elapsed_inc   = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;
        past_startup  = elapsed_inc > {1'b0, i_cfg.startup_ms};
        past_shutdown = elapsed_inc > {1'b0, i_cfg.shutdown_ms};
    end

    // one tick of the sequencer
    always_comb begin
        n_mode    = r_mode;
        n_elapsed = elapsed_inc;
        n_absence = r_absence;
        n_prev    = r_prev;
        n_wait    = r_wait;
        waited    = 1'b0;
        do_detect = 1'b0;
        may_count = 1'b0;
        go_off    = 1'b0;

        if (r_wait != '0) begin
            n_wait = r_wait - 1'b1;
            waited = 1'b1;
        end else if (i_button != r_prev) begin
            if (i_button) begin
                case (r_mode)
                    pbs_pkg::MODE_ON: begin
                        if (past_startup) begin
                            n_mode    = pbs_pkg::MODE_SHUTDOWN;
                            n_elapsed = '0;
                        end
                    end
                    pbs_pkg::MODE_SHUTDOWN: ;
                    default: begin
                        n_mode    = pbs_pkg::MODE_ON;
                        n_elapsed = '0;
                        n_absence = '0;
                    end
                endcase
            end
            n_prev = i_button;
            n_wait = i_cfg.debounce_ms;
        end else if (r_mode == pbs_pkg::MODE_SHUTDOWN) begin
            if (past_shutdown) begin
                go_off = 1'b1;
            end else begin
                do_detect = 1'b1;
                may_count = 1'b1;
            end
        end else if (r_mode == pbs_pkg::MODE_ON) begin
            do_detect = 1'b1;
            may_count = past_startup;
        end

        // appliance presence tracking
        if (do_detect) begin
            if (i_detect) begin
                n_absence = pbs_pkg::ABSENCE_W'(1);
            end else if (may_count && r_absence != '0) begin
                if (r_absence <= {1'b0, i_cfg.absence_limit}) begin
                    n_absence = r_absence + 1'b1;
                    n_wait    = i_cfg.absence_step_ms;
                end else begin
                    go_off = 1'b1;
                end
            end
        end

        if (go_off) begin
            n_mode    = pbs_pkg::MODE_OFF;
            n_elapsed = '0;
            n_prev    = 1'b0;
        end
    end

    // result word from the mode after this tick
    always_comb begin
        o_res.waiting = waited;
        case (n_mode)
            pbs_pkg::MODE_ON: begin
                o_res.relay_closed    = 1'b1;
                o_res.shutdown_signal = 1'b0;
                o_res.mode_code       = pbs_pkg::MODE_ON;
            end
            pbs_pkg::MODE_SHUTDOWN: begin
                o_res.relay_closed    = 1'b1;
                o_res.shutdown_signal = 1'b1;
                o_res.mode_code       = pbs_pkg::MODE_SHUTDOWN;
            end
            default: begin
                o_res.relay_closed    = 1'b0;
                o_res.shutdown_signal = 1'b0;
                o_res.mode_code       = pbs_pkg::MODE_OFF;
            end
        endcase
    end

    // state update, once per processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= pbs_pkg::MODE_OFF;
            r_elapsed <= '0;
            r_absence <= '0;
            r_prev    <= 1'b0;
            r_wait    <= '0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_elapsed <= n_elapsed;
            r_absence <= n_absence;
            r_prev    <= n_prev;
            r_wait    <= n_wait;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/power_button_sequencer_top.sv */
// Power button sequencer top level.
// Each input word is one millisecond tick carrying the button and appliance
// detect levels; each tick produces exactly one result word with the relay,
// shutdown request, mode code and a flag telling that the tick was ignored
// by a debounce or absence wait.
// Channels: i_in (sink) and o_out (source), valid/ready, a word moves when
// both are high. Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data
// only while the block is idle, a rule for the user that the block does not
// enforce; indexes past the register list are ignored. An accepted word
// passes the input register, then the result register, before its result
// is valid. Throughput: one word per cycle while o_out is not stalled; the
// sequencer state updates in the same cycle that the result register loads.
// When o_out is stalled the result register holds, the input register
// fills and then i_in.ready drops; no word is lost.
// Reset (synchronous, active low) returns the mode to off, clears all
// timers, empties both pipeline registers and loads default register values.
`default_nettype none

module power_button_sequencer_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    pbs_in_if.sink                              i_in,
    pbs_out_if.source                           o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [pbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pbs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    pbs_pkg::t_cfg    cfg;
    pbs_pkg::t_result res;
    logic             r_in_valid;
    logic             r_button;
    logic             r_detect;
    logic             r_out_valid;
    pbs_pkg::t_result r_res;
    logic             step;

    pbs_cfg_regs u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (i_cfg_we),
        .i_idx  (i_cfg_idx),
        .i_data (i_cfg_data),
        .o_cfg  (cfg)
    );

    // a word advances when the result register is free or being drained
    assign step       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_button <= i_in.button_level;
            r_detect <= i_in.detect_level;
        end
    end

    pbs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_button(r_button),
        .i_detect(r_detect),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.relay_closed    = r_res.relay_closed;
    assign o_out.shutdown_signal = r_res.shutdown_signal;
    assign o_out.mode_code       = r_res.mode_code;
    assign o_out.waiting         = r_res.waiting;

endmodule

`default_nettype wire
